FILE: rtl/lei_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lei_pkg
// Shared widths and register codes for the Lorenz Euler integrator.
// ----------------------------------------------------------------------------
package lei_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int PARAM_WIDTH    = 31;
   localparam int STEP_WIDTH     = 24;
   localparam int PROD_WIDTH     = 2 * COORD_WIDTH;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int REG_IDX_WIDTH  = 2;

   typedef logic [REG_IDX_WIDTH-1:0] reg_idx_type;

   localparam reg_idx_type REG_SIGMA     = 2'd0;
   localparam reg_idx_type REG_RHO       = 2'd1;
   localparam reg_idx_type REG_BETA      = 2'd2;
   localparam reg_idx_type REG_TIME_STEP = 2'd3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

endpackage : lei_pkg
`default_nettype wire

FILE: rtl/lei_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lei_channels
// Valid/ready channels: step requests in, integrated points out.
// ----------------------------------------------------------------------------
interface lei_req_if;
   logic valid;
   logic ready;
   logic step_request;

   modport source (output valid, output step_request, input ready);
   modport sink   (input valid, input step_request, output ready);
endinterface : lei_req_if

interface lei_rsp_if;
   import lei_pkg::*;

   logic      valid;
   logic      ready;
   coord_type pos_x;
   coord_type pos_y;
   coord_type pos_z;
   logic      saturated;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output saturated, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input saturated, output ready);
endinterface : lei_rsp_if
`default_nettype wire

FILE: rtl/lorenz_euler_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lorenz_euler_integrator
// Forward Euler step of the Lorenz system in signed Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries tick beats. A beat with step_request set advances the
//    point (x, y, z) by one Euler step; a beat with it clear is dropped.
//  - rsp_bus carries one beat per step: the new point and a flag that is set
//    if any intermediate or result clamped at the signed 32-bit limits.
//  - sigma, rho, beta and time_step sit on the csr_ APB port at byte
//    addresses 0, 4, 8 and 12; write them only while the block is idle.
//  - A step runs after its accept cycle as nine ordered operations on the
//    shared 32x32 multiplier and add/clamp unit; the result beat is
//    registered when the last one completes. req_bus is not ready while a
//    step is in flight.
//  - A finished beat waits in the output register while the next request
//    is accepted; a step stalls on its final cycle only if that register is
//    still held by an earlier beat.
//  - Reset puts the point at (1.0, 1.0, 1.0) and loads the default
//    parameters (10.0, 28.0, 2.6666, 0.007).
// ----------------------------------------------------------------------------
module lorenz_euler_integrator #(
   parameter int FRAC_BITS = 24
) (
   input  wire                                 clock,
   input  wire                                 reset,
   lei_req_if.sink                             req_bus,
   lei_rsp_if.source                           rsp_bus,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [lei_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire  [lei_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [lei_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import lei_pkg::*;

   // reset values, capped to the register width
   localparam longint unsigned MAX_PARAM = (64'd1 << PARAM_WIDTH) - 64'd1;
   localparam longint unsigned MAX_STEP  = (64'd1 << STEP_WIDTH) - 64'd1;
   localparam longint unsigned SIGMA_RAW = 64'd10 << FRAC_BITS;
   localparam longint unsigned RHO_RAW   = 64'd28 << FRAC_BITS;
   localparam longint unsigned BETA_RAW  = ((64'd26666 << FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam longint unsigned STEP_RAW  = ((64'd7 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam logic [PARAM_WIDTH-1:0] SIGMA_RST =
      PARAM_WIDTH'((SIGMA_RAW > MAX_PARAM) ? MAX_PARAM : SIGMA_RAW);
   localparam logic [PARAM_WIDTH-1:0] RHO_RST =
      PARAM_WIDTH'((RHO_RAW > MAX_PARAM) ? MAX_PARAM : RHO_RAW);
   localparam logic [PARAM_WIDTH-1:0] BETA_RST =
      PARAM_WIDTH'((BETA_RAW > MAX_PARAM) ? MAX_PARAM : BETA_RAW);
   localparam logic [STEP_WIDTH-1:0] STEP_RST =
      STEP_WIDTH'((STEP_RAW > MAX_STEP) ? MAX_STEP : STEP_RAW);
   localparam coord_type ONE_FIX = COORD_WIDTH'(64'd1 << FRAC_BITS);

   localparam int SUM_WIDTH = PROD_WIDTH + 1;

   // sequencer states, one shared-unit slot each
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SUB_YX  = 4'd1;
   localparam logic [3:0] ST_SUB_RZ  = 4'd2;
   localparam logic [3:0] ST_RATE_X  = 4'd3;
   localparam logic [3:0] ST_RATE_Y  = 4'd4;
   localparam logic [3:0] ST_PROD_XY = 4'd5;
   localparam logic [3:0] ST_RATE_Z  = 4'd6;
   localparam logic [3:0] ST_NEW_X   = 4'd7;
   localparam logic [3:0] ST_NEW_Y   = 4'd8;
   localparam logic [3:0] ST_NEW_Z   = 4'd9;

   logic [3:0]             state_ff, state_in;
   logic [PARAM_WIDTH-1:0] sigma_ff, rho_ff, beta_ff;
   logic [STEP_WIDTH-1:0]  step_ff;
   coord_type              coord_x_ff, coord_y_ff, coord_z_ff;
   coord_type              diff_ff, rate_x_ff, rate_y_ff, rate_z_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic signed [PROD_WIDTH-1:0] xy_ff;
   logic                   sat_ff;
   logic                   rsp_valid_ff;
   coord_type              rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                   rsp_sat_ff;

   logic                   csr_write;
   reg_idx_type            csr_idx;
   logic                   req_take;
   logic                   rsp_free;
   logic                   advance;
   logic                   mul_load;
   coord_type              mul_a, mul_b;
   logic signed [PROD_WIDTH-1:0] prod_sh;
   logic signed [PROD_WIDTH-1:0] alu_a, alu_b;
   logic                   alu_sub;
   logic signed [SUM_WIDTH-1:0] alu_sum;
   coord_type              alu_res;
   logic                   alu_clamp;
   logic                   alu_used;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[REG_IDX_WIDTH+1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_idx)
         REG_SIGMA:     csr_prdata = CSR_DATA_WIDTH'(sigma_ff);
         REG_RHO:       csr_prdata = CSR_DATA_WIDTH'(rho_ff);
         REG_BETA:      csr_prdata = CSR_DATA_WIDTH'(beta_ff);
         REG_TIME_STEP: csr_prdata = CSR_DATA_WIDTH'(step_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIGMA_RST;
         rho_ff   <= RHO_RST;
         beta_ff  <= BETA_RST;
         step_ff  <= STEP_RST;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_SIGMA:     sigma_ff <= csr_pwdata[PARAM_WIDTH-1:0];
            REG_RHO:       rho_ff   <= csr_pwdata[PARAM_WIDTH-1:0];
            REG_BETA:      beta_ff  <= csr_pwdata[PARAM_WIDTH-1:0];
            REG_TIME_STEP: step_ff  <= csr_pwdata[STEP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   // hold the last slot while the output register is still occupied
   assign advance       = (state_ff != ST_IDLE) && ((state_ff != ST_NEW_Z) || rsp_free);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_take && req_bus.step_request) begin
                        state_in = ST_SUB_YX;
                     end
         ST_SUB_YX:  state_in = ST_SUB_RZ;
         ST_SUB_RZ:  state_in = ST_RATE_X;
         ST_RATE_X:  state_in = ST_RATE_Y;
         ST_RATE_Y:  state_in = ST_PROD_XY;
         ST_PROD_XY: state_in = ST_RATE_Z;
         ST_RATE_Z:  state_in = ST_NEW_X;
         ST_NEW_X:   state_in = ST_NEW_Y;
         ST_NEW_Y:   state_in = ST_NEW_Z;
         ST_NEW_Z:   if (rsp_free) begin
                        state_in = ST_IDLE;
                     end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- multiplier
   always_comb begin
      mul_load = 1'b1;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         ST_SUB_RZ:  begin mul_a = coord_type'({1'b0, sigma_ff}); mul_b = diff_ff;    end
         ST_RATE_X:  begin mul_a = coord_x_ff;                    mul_b = diff_ff;    end
         ST_RATE_Y:  begin mul_a = coord_x_ff;                    mul_b = coord_y_ff; end
         ST_PROD_XY: begin mul_a = coord_type'({1'b0, beta_ff});  mul_b = coord_z_ff; end
         ST_RATE_Z:  begin mul_a = coord_type'({8'd0, step_ff});  mul_b = rate_x_ff;  end
         ST_NEW_X:   begin mul_a = coord_type'({8'd0, step_ff});  mul_b = rate_y_ff;  end
         ST_NEW_Y:   begin mul_a = coord_type'({8'd0, step_ff});  mul_b = rate_z_ff;  end
         default:    mul_load = 1'b0;
      endcase
   end

   assign prod_in = mul_a * mul_b;
   // floor shift back to the fixed-point scale
   assign prod_sh = prod_ff >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (mul_load) begin
         prod_ff <= prod_in;
      end
   end

   // ---------------------------------------------------------------- add/clamp unit
   always_comb begin
      alu_used = 1'b1;
      alu_sub  = 1'b1;
      alu_a    = '0;
      alu_b    = '0;
      unique case (state_ff)
         ST_SUB_YX: begin
            alu_a = PROD_WIDTH'(coord_y_ff);
            alu_b = PROD_WIDTH'(coord_x_ff);
         end
         ST_SUB_RZ: begin
            alu_a = PROD_WIDTH'({1'b0, rho_ff});
            alu_b = PROD_WIDTH'(coord_z_ff);
         end
         ST_RATE_X: begin
            alu_a = prod_sh;
         end
         ST_RATE_Y: begin
            alu_a = prod_sh;
            alu_b = PROD_WIDTH'(coord_y_ff);
         end
         ST_RATE_Z: begin
            alu_a = xy_ff;
            alu_b = prod_sh;
         end
         ST_NEW_X: begin
            alu_sub = 1'b0;
            alu_a   = PROD_WIDTH'(coord_x_ff);
            alu_b   = prod_sh;
         end
         ST_NEW_Y: begin
            alu_sub = 1'b0;
            alu_a   = PROD_WIDTH'(coord_y_ff);
            alu_b   = prod_sh;
         end
         ST_NEW_Z: begin
            alu_sub = 1'b0;
            alu_a   = PROD_WIDTH'(coord_z_ff);
            alu_b   = prod_sh;
         end
         default: alu_used = 1'b0;
      endcase
   end

   assign alu_sum = alu_sub ? (SUM_WIDTH'(alu_a) - SUM_WIDTH'(alu_b))
                            : (SUM_WIDTH'(alu_a) + SUM_WIDTH'(alu_b));

   always_comb begin
      alu_clamp = 1'b0;
      alu_res   = alu_sum[COORD_WIDTH-1:0];
      if (!alu_sum[SUM_WIDTH-1] && (|alu_sum[SUM_WIDTH-2:COORD_WIDTH-1])) begin
         alu_clamp = 1'b1;
         alu_res   = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (alu_sum[SUM_WIDTH-1] && !(&alu_sum[SUM_WIDTH-2:COORD_WIDTH-1])) begin
         alu_clamp = 1'b1;
         alu_res   = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end
   end

   // ---------------------------------------------------------------- step state
   always_ff @(posedge clock) begin
      if (reset) begin
         coord_x_ff <= ONE_FIX;
         coord_y_ff <= ONE_FIX;
         coord_z_ff <= ONE_FIX;
         sat_ff     <= 1'b0;
      end else begin
         if (req_take) begin
            sat_ff <= 1'b0;
         end else if (advance && alu_used) begin
            sat_ff <= sat_ff | alu_clamp;
         end
         if (advance) begin
            unique case (state_ff)
               ST_NEW_X: coord_x_ff <= alu_res;
               ST_NEW_Y: coord_y_ff <= alu_res;
               ST_NEW_Z: coord_z_ff <= alu_res;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_SUB_YX,
         ST_SUB_RZ:  diff_ff   <= alu_res;
         ST_RATE_X:  rate_x_ff <= alu_res;
         ST_RATE_Y:  rate_y_ff <= alu_res;
         ST_PROD_XY: xy_ff     <= prod_sh;
         ST_RATE_Z:  rate_z_ff <= alu_res;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && (state_ff == ST_NEW_Z)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && (state_ff == ST_NEW_Z)) begin
         rsp_x_ff   <= coord_x_ff;
         rsp_y_ff   <= coord_y_ff;
         rsp_z_ff   <= alu_res;
         rsp_sat_ff <= sat_ff | alu_clamp;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pos_x     = rsp_x_ff;
   assign rsp_bus.pos_y     = rsp_y_ff;
   assign rsp_bus.pos_z     = rsp_z_ff;
   assign rsp_bus.saturated = rsp_sat_ff;

endmodule : lorenz_euler_integrator
`default_nettype wire
